@@ design/p2f_pkg.sv @@
// Shared types, constants and the microcode table of the packet to flit segmenter.
// Used by p2f_sequencer, p2f_datapath and packet_to_flit_segmenter_top.
`default_nettype none

package p2f_pkg;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 176;
   localparam int SUBNET_W   = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [30:0] PRI_TOP = 31'h7FFF_FFFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRIORITY_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUBNET_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_COUNT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_PRI_0   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_PRI_1   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_PRI_2   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_PRI_3   = 3'd6;

   localparam logic [1:0] MODE_NONE     = 2'd0;
   localparam logic [1:0] MODE_CLASS    = 2'd1;
   localparam logic [1:0] MODE_AGE      = 2'd2;
   localparam logic [1:0] MODE_SEQUENCE = 2'd3;

   localparam logic [2:0] KIND_ANY = 3'd4;

   typedef logic [1:0] step_type;

   localparam step_type STEP_WAIT  = 2'd0;
   localparam step_type STEP_CHECK = 2'd1;
   localparam step_type STEP_FLIT  = 2'd2;
   localparam step_type STEP_ERROR = 2'd3;

   typedef enum logic [1:0] {
      COND_ACCEPT,
      COND_BAD,
      COND_FIRE,
      COND_FIRE_LAST
   } cond_type;

   typedef struct packed {
      logic     take;
      logic     emit;
      logic     err;
      cond_type cond;
      step_type target;
      logic     advance;
   } ucode_type;

   typedef struct packed {
      logic take;
      logic emit;
      logic err;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic bad;
      logic fire;
      logic last;
   } status_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [3:0]        subnets;
      logic [6:0]        nodes;
      logic [3:0][15:0]  class_pri;
   } cfg_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      word = '{take: 1'b0, emit: 1'b0, err: 1'b0, cond: COND_ACCEPT,
               target: STEP_WAIT, advance: 1'b0};
      unique case (step)
         STEP_WAIT: begin
            word = '{take: 1'b1, emit: 1'b0, err: 1'b0, cond: COND_ACCEPT,
                     target: STEP_CHECK, advance: 1'b0};
         end
         STEP_CHECK: begin
            word = '{take: 1'b0, emit: 1'b0, err: 1'b0, cond: COND_BAD,
                     target: STEP_ERROR, advance: 1'b1};
         end
         STEP_FLIT: begin
            word = '{take: 1'b0, emit: 1'b1, err: 1'b0, cond: COND_FIRE_LAST,
                     target: STEP_WAIT, advance: 1'b0};
         end
         STEP_ERROR: begin
            word = '{take: 1'b0, emit: 1'b1, err: 1'b1, cond: COND_FIRE,
                     target: STEP_WAIT, advance: 1'b0};
         end
         default: begin
            word = '{take: 1'b0, emit: 1'b0, err: 1'b0, cond: COND_ACCEPT,
                     target: STEP_WAIT, advance: 1'b0};
         end
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

@@ design/p2f_sequencer.sv @@
// Step counter and microcode fetch with conditional jumps.
// Depends on p2f_pkg for the control word table and the status and control structs.
`default_nettype none

module p2f_sequencer
   import p2f_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output ctrl_type        ctrl
);

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;
   logic      cond_met;

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_ACCEPT:    cond_met = status.accept;
         COND_BAD:       cond_met = status.bad;
         COND_FIRE:      cond_met = status.fire;
         COND_FIRE_LAST: cond_met = status.fire & status.last;
         default:        cond_met = 1'b0;
      endcase
   end

   always_comb begin
      priority if (cond_met) begin
         step_in = word.target;
      end else if (word.advance) begin
         step_in = step_ff + 2'd1;
      end else begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl = '{take: word.take, emit: word.emit, err: word.err};

endmodule

`default_nettype wire

@@ design/p2f_datapath.sv @@
// Request capture, checks, priority and kind, flit and packet counters and output register.
// Depends on p2f_pkg; driven by the control word from p2f_sequencer.
`default_nettype none

module p2f_datapath
   import p2f_pkg::*;
#(
   parameter int FLIT_BYTES  = 8,
   parameter int MAX_FLITS   = 64,
   parameter int NUM_CLASSES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire ctrl_type              ctrl,
   output status_type                 status,
   input  wire logic                  req_tvalid,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [SUBNET_W-1:0]   req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   localparam logic [9:0]  STEP_BYTES = 10'(FLIT_BYTES);
   localparam logic [12:0] MAX_BYTES  = 13'(MAX_FLITS * FLIT_BYTES);
   localparam logic [2:0]  CLASS_LIM  = 3'(NUM_CLASSES);

   logic [5:0]  src_ff;
   logic [1:0]  cls_ff;
   logic [30:0] created_ff;
   logic [31:0] tag_ff;
   logic [2:0]  subnet_ff;
   logic [6:0]  dest_ff;
   logic [30:0] seq_ff;
   logic [9:0]  rem_ff;
   logic [9:0]  rem_in;
   logic        head_ff;
   logic        head_in;
   logic        size_zero_ff;
   logic        size_big_ff;

   logic [31:0] flit_ctr_ff;
   logic [31:0] flit_ctr_in;
   logic [31:0] pkt_ctr_ff;
   logic [31:0] pkt_ctr_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;
   logic                  rsp_err_ff;
   logic                  rsp_err_in;

   logic        accept;
   logic        fire;
   logic        last;
   logic        bad;
   logic [6:0]  nodes;
   logic [2:0]  subnet_eff;
   logic        subnet_bad;
   logic [2:0]  kind;
   logic [30:0] pri;

   assign accept = req_tvalid & ctrl.take;
   assign fire   = ctrl.emit & (~rsp_valid_ff | rsp_tready);
   assign last   = rem_ff <= STEP_BYTES;

   assign nodes = (cfg.nodes > 7'd64) ? 7'd64 : cfg.nodes;

   always_comb begin
      subnet_bad = 1'b0;
      subnet_eff = subnet_ff;
      if (cfg.subnets == 4'd1) begin
         subnet_eff = 3'd0;
      end else if ({1'b0, subnet_ff} >= cfg.subnets) begin
         subnet_bad = 1'b1;
      end
   end

   assign bad  = (dest_ff >= nodes) | subnet_bad | size_zero_ff | size_big_ff;
   assign kind = (subnet_eff < 3'd4) ? subnet_eff : KIND_ANY;

   always_comb begin
      unique case (cfg.mode)
         MODE_CLASS: begin
            pri = ({1'b0, cls_ff} < CLASS_LIM) ? {15'd0, cfg.class_pri[cls_ff]} : 31'd0;
         end
         MODE_AGE:      pri = PRI_TOP - created_ff;
         MODE_SEQUENCE: pri = PRI_TOP - seq_ff;
         MODE_NONE:     pri = 31'd0;
         default:       pri = 31'd0;
      endcase
   end

   always_comb begin
      rem_in      = rem_ff;
      head_in     = head_ff;
      flit_ctr_in = flit_ctr_ff;
      pkt_ctr_in  = pkt_ctr_ff;
      if (accept) begin
         rem_in  = req_tdata[15:6];
         head_in = 1'b1;
      end else if (fire && !ctrl.err) begin
         rem_in      = last ? rem_ff : rem_ff - STEP_BYTES;
         head_in     = 1'b0;
         flit_ctr_in = flit_ctr_ff + 32'd1;
         if (last) begin
            pkt_ctr_in = pkt_ctr_ff + 32'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = ctrl.err;
         rsp_last_in  = ctrl.err | last;
         rsp_data_in  = {tag_ff,
                         created_ff,
                         ctrl.err ? 31'd0 : pri,
                         cls_ff,
                         src_ff,
                         ctrl.err ? 3'd0 : kind,
                         (head_ff && !ctrl.err) ? dest_ff[5:0] : 6'd0,
                         head_ff & ~ctrl.err,
                         pkt_ctr_ff,
                         flit_ctr_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff       <= req_tdata[5:0];
         cls_ff       <= req_tdata[17:16];
         created_ff   <= req_tdata[48:18];
         tag_ff       <= req_tdata[80:49];
         dest_ff      <= req_tdata[87:81];
         seq_ff       <= req_tdata[118:88];
         subnet_ff    <= req_tuser;
         size_zero_ff <= req_tdata[15:6] == 10'd0;
         size_big_ff  <= {3'd0, req_tdata[15:6]} > MAX_BYTES;
      end
      rem_ff      <= rem_in;
      head_ff     <= head_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flit_ctr_ff  <= 32'd0;
         pkt_ctr_ff   <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flit_ctr_ff  <= flit_ctr_in;
         pkt_ctr_ff   <= pkt_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status     = '{accept: accept, bad: bad, fire: fire, last: last};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

@@ design/packet_to_flit_segmenter_top.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  req_tdata, req_tuser (subnet index)
// rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tlast (tail), rsp_tuser (error)
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// A packet passes one step to take the transaction, one check step, then one flit
// per cycle from the microcoded flit step while the output is ready; a bad request
// goes to an error step. Output backpressure holds the flit step; the output register lets
// the next request be taken while the last result still waits. Reset is synchronous
// and needs no clearing pass. Top level: registers, sequencer and datapath.
`default_nettype none

module packet_to_flit_segmenter_top
   import p2f_pkg::*;
#(
   parameter int FLIT_BYTES  = 8,
   parameter int MAX_FLITS   = 64,
   parameter int NUM_CLASSES = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // source_node, size_bytes, traffic_class, create_time, request_tag, dest_node,
   // sequence_number, then one zero pad bit
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // subnet_index
   input  wire logic [SUBNET_W-1:0]    req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // flit_number, packet_number, is_head, dest_out, flit_kind, source_out, class_out,
   // priority_out, created_out, tag_out
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tlast,
   // error_flag
   output logic                        rsp_tuser,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   ctrl_type   ctrl;
   status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRIORITY_MODE: cfg_in.mode         = csr_data[1:0];
            CSR_SUBNET_COUNT:  cfg_in.subnets      = csr_data[3:0];
            CSR_NODE_COUNT:    cfg_in.nodes        = csr_data[6:0];
            CSR_CLASS_PRI_0:   cfg_in.class_pri[0] = csr_data;
            CSR_CLASS_PRI_1:   cfg_in.class_pri[1] = csr_data;
            CSR_CLASS_PRI_2:   cfg_in.class_pri[2] = csr_data;
            CSR_CLASS_PRI_3:   cfg_in.class_pri[3] = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: MODE_NONE, subnets: 4'd1, nodes: 7'd64, class_pri: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   p2f_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   p2f_datapath #(
      .FLIT_BYTES  (FLIT_BYTES),
      .MAX_FLITS   (MAX_FLITS),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = ctrl.take;

`ifndef SYNTHESIS
   a_error_is_tail : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && !rsp_tdata[64])
      else $error("error transaction without tail or with head mark");

   a_take_one : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken before the first was segmented");

   a_no_emit_while_taking : assert property (@(posedge clock) disable iff (reset)
      ctrl.take |-> !ctrl.emit && !status.fire)
      else $error("flit emitted during the request step");
`endif

endmodule

`default_nettype wire

@@ dv/packet_to_flit_segmenter_top_tb.sv @@
// Self-checking testbench for packet_to_flit_segmenter_top.
// A scoreboard class predicts the flits of every accepted packet request and checks
// each flit. Depends on p2f_pkg and the top module.
`timescale 1ns / 1ps

module packet_to_flit_segmenter_top_tb;
   import p2f_pkg::*;

   localparam int FLIT_BYTES  = 8;
   localparam int MAX_FLITS   = 64;
   localparam int NUM_CLASSES = 4;

   typedef struct {
      logic [5:0]  source;
      logic [9:0]  size;
      logic [1:0]  cls;
      logic [30:0] created;
      logic [31:0] tag;
      logic [2:0]  subnet;
      logic [6:0]  dest;
      logic [30:0] seq;
   } packet_type;

   typedef struct {
      logic [31:0] flit_number;
      logic [31:0] packet_number;
      logic        head;
      logic        tail;
      logic [5:0]  dest;
      logic [2:0]  kind;
      logic [5:0]  source;
      logic [1:0]  cls;
      logic [30:0] priority_val;
      logic [30:0] created;
      logic [31:0] tag;
      logic        error;
   } flit_type;

   class flit_scoreboard;
      logic [1:0]  mode;
      logic [3:0]  subnets;
      logic [6:0]  nodes;
      logic [15:0] class_pri [4];
      logic [31:0] packet_count;
      logic [31:0] flit_count;
      flit_type    expected_flits [$];
      int          errors;

      function new();
         mode = MODE_NONE;
         subnets = 4'd1;
         nodes = 7'd64;
         foreach (class_pri[i]) class_pri[i] = 16'd0;
         packet_count = 32'd0;
         flit_count = 32'd0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [15:0] value);
         case (index)
            CSR_PRIORITY_MODE: mode = value[1:0];
            CSR_SUBNET_COUNT:  subnets = value[3:0];
            CSR_NODE_COUNT:    nodes = value[6:0];
            CSR_CLASS_PRI_0:   class_pri[0] = value;
            CSR_CLASS_PRI_1:   class_pri[1] = value;
            CSR_CLASS_PRI_2:   class_pri[2] = value;
            CSR_CLASS_PRI_3:   class_pri[3] = value;
            default: ;
         endcase
      endfunction

      function int node_limit();
         return (nodes > 7'd64) ? 64 : int'(nodes);
      endfunction

      function void note_packet(packet_type p);
         flit_type f;
         int count;
         logic [2:0] subnet;
         logic bad;
         count = (int'(p.size) + FLIT_BYTES - 1) / FLIT_BYTES;
         subnet = p.subnet;
         bad = (int'(p.dest) >= node_limit());
         if (subnets == 4'd1) subnet = 3'd0;
         else if ({1'b0, subnet} >= subnets) bad = 1'b1;
         if (p.size == 10'd0 || count > MAX_FLITS) bad = 1'b1;
         f.flit_number = flit_count;
         f.packet_number = packet_count;
         f.source = p.source;
         f.cls = p.cls;
         f.created = p.created;
         f.tag = p.tag;
         if (bad) begin
            f.head = 1'b0;
            f.tail = 1'b1;
            f.dest = 6'd0;
            f.kind = 3'd0;
            f.priority_val = 31'd0;
            f.error = 1'b1;
            expected_flits.insert(expected_flits.size(), f);
            return;
         end
         f.kind = (subnet < 3'd4) ? subnet : KIND_ANY;
         f.error = 1'b0;
         case (mode)
            MODE_CLASS:    f.priority_val = (int'(p.cls) < NUM_CLASSES) ?
                                            31'(class_pri[p.cls]) : 31'd0;
            MODE_AGE:      f.priority_val = PRI_TOP - p.created;
            MODE_SEQUENCE: f.priority_val = PRI_TOP - p.seq;
            default:       f.priority_val = 31'd0;
         endcase
         for (int i = 0; i < count; i++) begin
            f.flit_number = flit_count;
            f.head = (i == 0);
            f.tail = (i == count - 1);
            f.dest = (i == 0) ? p.dest[5:0] : 6'd0;
            expected_flits.insert(expected_flits.size(), f);
            flit_count = flit_count + 32'd1;
         end
         packet_count = packet_count + 32'd1;
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_flit(flit_type got);
         flit_type want;
         if (expected_flits.size() == 0) begin
            $display("%0t: flit with nothing expected, actual flit %0h packet %0h",
                     $time, got.flit_number, got.packet_number);
            errors++;
            return;
         end
         want = expected_flits[0];
         expected_flits.delete(0);
         check_field("flit_number", want.flit_number, got.flit_number);
         check_field("packet_number", want.packet_number, got.packet_number);
         check_field("is_head", 32'(want.head), 32'(got.head));
         check_field("is_tail", 32'(want.tail), 32'(got.tail));
         check_field("dest_out", 32'(want.dest), 32'(got.dest));
         check_field("flit_kind", 32'(want.kind), 32'(got.kind));
         check_field("source_out", 32'(want.source), 32'(got.source));
         check_field("class_out", 32'(want.cls), 32'(got.cls));
         check_field("priority_out", 32'(want.priority_val), 32'(got.priority_val));
         check_field("created_out", 32'(want.created), 32'(got.created));
         check_field("tag_out", want.tag, got.tag);
         check_field("error_flag", 32'(want.error), 32'(got.error));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [SUBNET_W-1:0]    req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   flit_scoreboard sb = new();
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;

   packet_to_flit_segmenter_top #(
      .FLIT_BYTES(FLIT_BYTES),
      .MAX_FLITS(MAX_FLITS),
      .NUM_CLASSES(NUM_CLASSES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      flit_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.flit_number = rsp_tdata[31:0];
         seen.packet_number = rsp_tdata[63:32];
         seen.head = rsp_tdata[64];
         seen.dest = rsp_tdata[70:65];
         seen.kind = rsp_tdata[73:71];
         seen.source = rsp_tdata[79:74];
         seen.cls = rsp_tdata[81:80];
         seen.priority_val = rsp_tdata[112:82];
         seen.created = rsp_tdata[143:113];
         seen.tag = rsp_tdata[175:144];
         seen.tail = rsp_tlast;
         seen.error = rsp_tuser;
         sb.check_flit(seen);
      end
   end

   task automatic send_packet(packet_type p);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, p.seq, p.dest, p.tag, p.created, p.cls, p.size, p.source};
      req_tuser <= p.subnet;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_packet(p);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_flits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [1:0] mode, logic [3:0] subnets, logic [6:0] nodes,
                            logic [15:0] p0, logic [15:0] p1, logic [15:0] p2,
                            logic [15:0] p3);
      logic [15:0] values [7];
      values = '{16'(mode), 16'(subnets), 16'(nodes), p0, p1, p2, p3};
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_reg(CSR_INDEX_W'(i), values[i]);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic packet_type make_packet(logic [9:0] size, logic [2:0] subnet,
                                              logic [6:0] dest);
      packet_type p;
      p.source = 6'($urandom);
      p.size = size;
      p.cls = 2'($urandom);
      p.created = 31'($urandom);
      p.tag = $urandom;
      p.subnet = subnet;
      p.dest = dest;
      p.seq = 31'($urandom);
      return p;
   endfunction

   function automatic packet_type random_packet();
      int sel;
      logic [9:0] size;
      logic [2:0] subnet;
      logic [6:0] dest;
      sel = $urandom_range(99);
      if (sel < 15)
         return make_packet(10'($urandom), 3'($urandom), 7'($urandom));
      if (sel < 80) size = 10'($urandom_range(1, 64));
      else if (sel < 93) size = 10'($urandom_range(65, 256));
      else size = 10'($urandom_range(257, 512));
      dest = (sb.node_limit() == 0) ? 7'd0 : 7'($urandom_range(0, sb.node_limit() - 1));
      subnet = (sb.subnets <= 4'd1 || sb.subnets > 4'd8) ? 3'($urandom) :
               3'($urandom_range(0, int'(sb.subnets) - 1));
      return make_packet(size, subnet, dest);
   endfunction

   initial begin
      packet_type p;
      logic [3:0] subnet_pick [5];
      logic [6:0] node_pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct = 20;
      stall_pct = 10;
      send_packet(make_packet(10'd1, 3'd0, 7'd0));
      send_packet(make_packet(10'd8, 3'd0, 7'd5));
      send_packet(make_packet(10'd9, 3'd7, 7'd10));
      p = '{6'h3F, 10'd512, 2'd3, PRI_TOP, 32'hFFFF_FFFF, 3'd0, 7'd63, PRI_TOP};
      send_packet(p);
      send_packet(make_packet(10'd0, 3'd0, 7'd1));
      send_packet(make_packet(10'd513, 3'd0, 7'd1));
      send_packet(make_packet(10'd1023, 3'd0, 7'd1));
      send_packet(make_packet(10'd16, 3'd0, 7'd64));
      send_packet(make_packet(10'd16, 3'd0, 7'd127));
      drain();

      configure(MODE_CLASS, 4'd8, 7'd127, 16'h0000, 16'h0001, 16'h8000, 16'hFFFF);
      for (int s = 0; s < 8; s++) begin
         p = make_packet(10'd16, 3'(s), (s == 7) ? 7'd63 : 7'(s));
         p.cls = 2'(s);
         send_packet(p);
      end
      drain();

      configure(MODE_AGE, 4'd5, 7'd1, 16'h1234, 16'h0, 16'hFFFF, 16'h5555);
      send_packet(make_packet(10'd24, 3'd4, 7'd0));
      send_packet(make_packet(10'd24, 3'd5, 7'd0));
      send_packet(make_packet(10'd24, 3'd0, 7'd1));
      drain();

      configure(MODE_SEQUENCE, 4'd0, 7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_packet(make_packet(10'd8, 3'd0, 7'd0));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         subnet_pick = '{4'd1, 4'd2, 4'd4, 4'd8, 4'($urandom)};
         case ($urandom_range(2))
            0: node_pick = 7'd64;
            1: node_pick = 7'($urandom_range(1, 64));
            default: node_pick = 7'($urandom);
         endcase
         configure(2'($urandom), (phase == 1) ? 4'd15 : subnet_pick[$urandom_range(4)],
                   node_pick, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
         case (phase % 3)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 10;
               stall_pct = 8;
            end
            default: begin
               gap_pct = 30;
               stall_pct = 25;
            end
         endcase
         if (phase == 5) begin
            gap_pct = 0;
            stall_pct = 0;
         end
         for (int n = 0; n < 52; n++) begin
            if (phase == 2 && n == 25) drain();
            send_packet(random_packet());
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_flits.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
